// ===== design/plc_pkg.sv =====
// plc_pkg: shared constants for the clamped pid regulator
// command codes, configuration register indexes, elapsed counter sizing
// no dependencies
package plc_pkg;

  // command carried in the input tuser bit
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_SETPOINT      = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KP_GAIN       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KI_GAIN       = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_KD_GAIN       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_MIN       = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_MAX       = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_PERIOD = 3'd6;

  // millisecond counter and sample period
  localparam int unsigned ELAPSED_W = 16;
  localparam logic [ELAPSED_W-1:0] ELAPSED_ALL_ONES = {ELAPSED_W{1'b1}};
  localparam logic [ELAPSED_W-1:0] SAMPLE_PERIOD_RESET = 16'd100;

endpackage

// ===== design/plc_mulq.sv =====
// plc_mulq: signed fixed point multiply, result floored by FRAC fraction bits
// purely combinational; used by pid_loop_clamped for the three gain terms
// no package dependencies
module plc_mulq #(
  parameter int unsigned AW   = 16,
  parameter int unsigned BW   = 17,
  parameter int unsigned FRAC = 8
) (
  input  logic signed [AW-1:0]      a_i,
  input  logic signed [BW-1:0]      b_i,
  output logic signed [AW+BW-FRAC-1:0] p_o
);

  logic signed [AW+BW-1:0] prod;

  assign prod = $signed(a_i) * $signed(b_i);
  // dropping the low bits of a two's complement value rounds toward minus infinity
  assign p_o  = prod[AW+BW-1:FRAC];

endmodule

// ===== design/pid_loop_clamped.sv =====
// pid_loop_clamped: sampled pid regulator with derivative on measurement
// and clamped drive; uses plc_pkg constants and plc_mulq for the gain products
//
// Usage:
//  - input stream: s_axis_tuser is the command (0 = millisecond tick,
//    1 = sample request), s_axis_tdata carries the signed measurement
//  - output stream: one result per input item; m_axis_tdata is the held,
//    clamped drive and m_axis_tuser is set when the item made an update
//  - config port: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
//    (0 setpoint, 1 kp, 2 ki, 3 kd, 4 out_min, 5 out_max, 6 sample_period);
//    write only while no request is in flight
//  - the gain multipliers sit in the first stage, integral update, sum and
//    clamp in the second; each stage ends in a register
//  - one item per cycle while results are taken; the output register and the
//    product stage let a new request enter while a result waits
//  - a stalled receiver holds the output; once both stages are full the
//    input tready drops until the output is taken
//  - reset loads the register defaults, clears integral, last measurement
//    and drive, and sets the elapsed counter to all ones so the first
//    sample request fires
module pid_loop_clamped #(
  parameter int unsigned DATA_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned ACC_WIDTH  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                              cfg_we_i,
  input  logic [plc_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [((DATA_WIDTH > 16) ? DATA_WIDTH : 16)-1:0] cfg_wdata_i,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // measurement
  input  logic                              s_axis_tuser,  // cmd

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // drive, zero padded
  output logic                              m_axis_tuser   // updated
);

  localparam int unsigned D  = DATA_WIDTH;
  localparam int unsigned TW = ((DATA_WIDTH+7)/8)*8;
  localparam int unsigned EW = D + 1;                 // error / delta width
  localparam int unsigned KW = D + EW - FRAC_BITS;    // scaled product width
  localparam int unsigned MW = (ACC_WIDTH > KW) ? ACC_WIDTH : KW;
  localparam int unsigned IW = MW + 1;                // integral sum width
  localparam int unsigned YW = MW + 2;                // raw drive width

  localparam logic [D-1:0] KP_RESET      = {{(D-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [D-1:0] OUT_MIN_RESET = {1'b1, {(D-1){1'b0}}};
  localparam logic [D-1:0] OUT_MAX_RESET = {1'b0, {(D-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // configuration registers
  logic signed [D-1:0] setpoint_q, kp_q, ki_q, kd_q, out_min_q, out_max_q;
  logic [plc_pkg::ELAPSED_W-1:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      kp_q       <= KP_RESET;
      ki_q       <= '0;
      kd_q       <= '0;
      out_min_q  <= OUT_MIN_RESET;
      out_max_q  <= OUT_MAX_RESET;
      period_q   <= plc_pkg::SAMPLE_PERIOD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        plc_pkg::REG_SETPOINT:      setpoint_q <= cfg_wdata_i[D-1:0];
        plc_pkg::REG_KP_GAIN:       kp_q       <= cfg_wdata_i[D-1:0];
        plc_pkg::REG_KI_GAIN:       ki_q       <= cfg_wdata_i[D-1:0];
        plc_pkg::REG_KD_GAIN:       kd_q       <= cfg_wdata_i[D-1:0];
        plc_pkg::REG_OUT_MIN:       out_min_q  <= cfg_wdata_i[D-1:0];
        plc_pkg::REG_OUT_MAX:       out_max_q  <= cfg_wdata_i[D-1:0];
        plc_pkg::REG_SAMPLE_PERIOD: period_q   <= cfg_wdata_i[plc_pkg::ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_q, p_valid_q;
  logic out_adv, p_move, in_acc;

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign p_move        = p_valid_q && out_adv;
  assign s_axis_tready = !p_valid_q || out_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // stage 1: fire decision, counter and last measurement, gain products
  logic [plc_pkg::ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic signed [D-1:0] last_meas_q, last_meas_d;
  logic signed [D-1:0] meas;
  logic signed [EW-1:0] err, dmeas;
  logic signed [KW-1:0] kp_term, ki_term, kd_term;
  logic fire;

  assign meas  = s_axis_tdata[D-1:0];
  assign fire  = (s_axis_tuser == plc_pkg::CMD_SAMPLE) && (elapsed_q >= period_q);
  assign err   = $signed({setpoint_q[D-1], setpoint_q}) - $signed({meas[D-1], meas});
  assign dmeas = $signed({meas[D-1], meas}) - $signed({last_meas_q[D-1], last_meas_q});

  always_comb begin
    elapsed_d   = elapsed_q;
    last_meas_d = last_meas_q;
    if (in_acc) begin
      if (s_axis_tuser == plc_pkg::CMD_TICK) begin
        if (elapsed_q != plc_pkg::ELAPSED_ALL_ONES) begin
          elapsed_d = elapsed_q + 1'b1;
        end
      end else if (fire) begin
        elapsed_d   = '0;
        last_meas_d = meas;
      end
    end
  end

  plc_mulq #(.AW(D), .BW(EW), .FRAC(FRAC_BITS)) u_mul_kp (
    .a_i(kp_q), .b_i(err), .p_o(kp_term)
  );
  plc_mulq #(.AW(D), .BW(EW), .FRAC(FRAC_BITS)) u_mul_ki (
    .a_i(ki_q), .b_i(err), .p_o(ki_term)
  );
  plc_mulq #(.AW(D), .BW(EW), .FRAC(FRAC_BITS)) u_mul_kd (
    .a_i(kd_q), .b_i(dmeas), .p_o(kd_term)
  );

  logic p_fire_q;
  logic signed [KW-1:0] p_kp_q, p_ki_q, p_kd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= plc_pkg::ELAPSED_ALL_ONES;
      last_meas_q <= '0;
      p_valid_q   <= 1'b0;
      p_fire_q    <= 1'b0;
    end else begin
      elapsed_q   <= elapsed_d;
      last_meas_q <= last_meas_d;
      if (in_acc) begin
        p_valid_q <= 1'b1;
        p_fire_q  <= fire;
      end else if (out_adv) begin
        p_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_kp_q <= kp_term;
      p_ki_q <= ki_term;
      p_kd_q <= kd_term;
    end
  end

  // stage 2: integral with saturation, raw drive, clamp
  logic signed [ACC_WIDTH-1:0] integ_q, integ_d;
  logic signed [IW-1:0] integ_sum;
  logic [IW-ACC_WIDTH:0] integ_top;
  logic signed [YW-1:0] y_raw, y_max, y_min;
  logic signed [D-1:0] y_clamp;

  assign integ_sum = $signed({{(IW-ACC_WIDTH){integ_q[ACC_WIDTH-1]}}, integ_q})
                   + $signed({{(IW-KW){p_ki_q[KW-1]}}, p_ki_q});
  assign integ_top = integ_sum[IW-1:ACC_WIDTH-1];

  always_comb begin
    if ((&integ_top) || !(|integ_top)) begin
      integ_d = integ_sum[ACC_WIDTH-1:0];
    end else if (integ_sum[IW-1]) begin
      integ_d = ACC_MIN;
    end else begin
      integ_d = ACC_MAX;
    end
  end

  assign y_raw = $signed({{(YW-KW){p_kp_q[KW-1]}}, p_kp_q})
               + $signed({{(YW-ACC_WIDTH){integ_d[ACC_WIDTH-1]}}, integ_d})
               - $signed({{(YW-KW){p_kd_q[KW-1]}}, p_kd_q});
  assign y_max = $signed({{(YW-D){out_max_q[D-1]}}, out_max_q});
  assign y_min = $signed({{(YW-D){out_min_q[D-1]}}, out_min_q});

  // upper bound is tested first, so it wins whenever y_raw is above it
  always_comb begin
    if (y_raw > y_max) begin
      y_clamp = out_max_q;
    end else if (y_raw < y_min) begin
      y_clamp = out_min_q;
    end else begin
      y_clamp = y_raw[D-1:0];
    end
  end

  // output register; drive doubles as the held drive
  logic signed [D-1:0] drive_q;
  logic updated_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      updated_q   <= 1'b0;
      drive_q     <= '0;
      integ_q     <= '0;
    end else if (out_adv) begin
      out_valid_q <= p_valid_q;
      if (p_valid_q) begin
        updated_q <= p_fire_q;
        if (p_fire_q) begin
          drive_q <= y_clamp;
          integ_q <= integ_d;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(TW-D){1'b0}}, drive_q};
  assign m_axis_tuser  = updated_q;

  // checks
  a_clamp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && p_fire_q && (out_min_q <= out_max_q))
      |-> (y_clamp >= out_min_q && y_clamp <= out_max_q))
    else $error("clamped drive outside bounds");

  a_fire_clears_elapsed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fire) |=> (elapsed_q == '0))
    else $error("elapsed counter not cleared after update");

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (p_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  a_tick_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_move && !p_fire_q) |=> (!m_axis_tuser && $stable(drive_q)))
    else $error("non-update item changed the drive");

endmodule
